/* rtl/iee_pkg.sv */
// Shared constants, types and helpers for the infix expression evaluator.
// No dependencies.
package iee_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int PTR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        K_DIGIT = 2'd0,
        K_LPAR  = 2'd1,
        K_RPAR  = 2'd2,
        K_OPER  = 2'd3
    } t_kind;

    // classified item passed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] sym;
        logic [1:0] prec;
        logic       last;
    } t_item;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
        if (c == CH_MUL || c == CH_DIV) p = 2'd2;
        return p;
    endfunction

endpackage

/* rtl/iee_front.sv */
// Front part: accepts characters, classifies them, holds them in a small queue.
// Depends on iee_pkg.
module iee_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_symbol,
    input  logic             i_last,
    output logic             o_item_valid,
    output iee_pkg::t_item   o_item,
    input  logic             i_item_take
);
    // two entries, 1-bit pointers
    iee_pkg::t_item r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    iee_pkg::t_item w_item;
    logic w_push, w_pop;

    always_comb begin
        w_item.sym  = i_symbol;
        w_item.last = i_last;
        w_item.prec = iee_pkg::prec_of(i_symbol);
        if (i_symbol >= iee_pkg::CH_ZERO && i_symbol <= iee_pkg::CH_NINE) begin
            w_item.kind = iee_pkg::K_DIGIT;
        end else if (i_symbol == iee_pkg::CH_LPAR) begin
            w_item.kind = iee_pkg::K_LPAR;
        end else if (i_symbol == iee_pkg::CH_RPAR) begin
            w_item.kind = iee_pkg::K_RPAR;
        end else begin
            w_item.kind = iee_pkg::K_OPER;
        end
    end

    assign o_stall      = (r_cnt == 2'd2);
    assign w_push       = i_valid && !o_stall;
    assign o_item_valid = (r_cnt != 2'd0);
    assign w_pop        = o_item_valid && i_item_take;
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

/* rtl/iee_div.sv */
// Radix-2 signed divider, truncating toward zero, one quotient bit a cycle.
// Depends on nothing.
module iee_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_q
);
    logic [31:0] r_rem, r_quo, r_mb;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg;
    logic [32:0] w_trial;
    logic [32:0] w_shift;

    assign w_shift = {r_rem, r_quo[31]};
    assign w_trial = w_shift - {1'b0, r_mb};
    assign o_q = r_neg ? (32'd0 - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= i_a[31] ? (32'd0 - i_a) : i_a;
            r_mb  <= i_b[31] ? (32'd0 - i_b) : i_b;
            r_neg <= i_a[31] ^ i_b[31];
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_shift[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

/* rtl/iee_back.sv */
// Back part: two stacks in memories, reduce sequencer, result register.
// Depends on iee_pkg and iee_div.
module iee_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  iee_pkg::t_item   i_item,
    output logic             o_item_take,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [31:0]      o_value,
    output logic             o_error
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PEEK   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_POP1   = 9'b000001000,
        S_POP2   = 9'b000010000,
        S_CALC   = 9'b000100000,
        S_MUL    = 9'b001000000,
        S_DIVW   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state;
    logic [31:0] r_vmem [iee_pkg::STACK_DEPTH];
    logic [7:0]  r_omem [iee_pkg::STACK_DEPTH];
    logic [iee_pkg::CNT_W-1:0] r_vtop, r_otop;
    logic [31:0] r_vrd;
    logic [7:0]  r_ord;
    logic [31:0] r_right, r_left, r_res;
    logic [7:0]  r_op;
    logic        r_err, r_final;
    iee_pkg::t_item r_it;
    logic [iee_pkg::PTR_W-1:0] w_vidx, w_oidx;
    logic        w_dstart, w_ddone;
    logic [31:0] w_dq;
    logic        w_vfull, w_ofull, w_reduce;
    logic [31:0] w_prod;

    assign w_vfull = (r_vtop == iee_pkg::CNT_W'(iee_pkg::STACK_DEPTH));
    assign w_ofull = (r_otop == iee_pkg::CNT_W'(iee_pkg::STACK_DEPTH));
    assign w_vidx  = iee_pkg::PTR_W'(r_vtop - 1'b1);
    assign w_oidx  = iee_pkg::PTR_W'(r_otop - 1'b1);
    assign o_item_take = (r_state == S_IDLE);
    assign w_prod = r_left * r_right;
    // both operands are settled once S_MUL is reached
    assign w_dstart = (r_state == S_MUL) && (r_op == iee_pkg::CH_DIV) && (r_right != 32'd0);

    iee_div u_div (
        .i_clk, .i_rst_n, .i_start(w_dstart), .i_a(r_left), .i_b(r_right),
        .o_done(w_ddone), .o_q(w_dq)
    );

    // reduce wanted at the top operator r_ord (valid when r_otop != 0);
    // the final flush reduces every operator, '(' included
    always_comb begin
        w_reduce = 1'b0;
        if (r_final) begin
            w_reduce = (r_otop != '0);
        end else if (r_otop != '0 && r_ord != iee_pkg::CH_LPAR) begin
            if (r_it.kind == iee_pkg::K_RPAR) begin
                w_reduce = 1'b1;
            end else if (r_it.kind == iee_pkg::K_OPER) begin
                w_reduce = iee_pkg::prec_of(r_ord) >= r_it.prec;
            end
        end
    end

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        r_vrd <= r_vmem[w_vidx];
        r_ord <= r_omem[w_oidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vtop  <= '0;
            r_otop  <= '0;
            r_err   <= 1'b0;
            r_final <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_OUT) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_it <= i_item;
                        unique case (i_item.kind)
                            iee_pkg::K_DIGIT: begin
                                if (!w_vfull) begin
                                    r_vmem[iee_pkg::PTR_W'(r_vtop)] <=
                                        {28'd0, i_item.sym[3:0]};
                                    r_vtop <= r_vtop + 1'b1;
                                end
                            end
                            iee_pkg::K_LPAR: begin
                                if (!w_ofull) begin
                                    r_omem[iee_pkg::PTR_W'(r_otop)] <= i_item.sym;
                                    r_otop <= r_otop + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                        if (i_item.kind == iee_pkg::K_DIGIT
                            || i_item.kind == iee_pkg::K_LPAR) begin
                            r_final <= i_item.last;
                            r_state <= i_item.last ? S_PEEK : S_IDLE;
                        end else begin
                            r_final <= 1'b0;
                            r_state <= S_PEEK;
                        end
                    end
                end
                S_PEEK: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (w_reduce) begin
                        r_op    <= r_ord;
                        r_otop  <= r_otop - 1'b1;
                        r_state <= S_POP1;
                    end else if (r_final) begin
                        r_state <= S_OUT;
                    end else begin
                        // operator handling done for this character
                        if (r_it.kind == iee_pkg::K_RPAR) begin
                            if (r_otop != '0) r_otop <= r_otop - 1'b1;
                        end else if (!w_ofull) begin
                            r_omem[iee_pkg::PTR_W'(r_otop)] <= r_it.sym;
                            r_otop <= r_otop + 1'b1;
                        end
                        if (r_it.last) begin
                            r_final <= 1'b1;
                            r_state <= S_PEEK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_POP1: begin
                    // r_vrd holds top value
                    if (r_vtop != '0) begin
                        r_right <= r_vrd;
                        r_vtop  <= r_vtop - 1'b1;
                    end else begin
                        r_right <= 32'hFFFF_FFFF;
                    end
                    r_state <= S_POP2;
                end
                S_POP2: begin
                    // read address changed last cycle; r_vrd is fresh next cycle
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (r_vtop != '0) begin
                        r_left <= r_vrd;
                        r_vtop <= r_vtop - 1'b1;
                    end else begin
                        r_left <= 32'hFFFF_FFFF;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    unique case (r_op)
                        iee_pkg::CH_PLUS:  r_res <= r_left + r_right;
                        iee_pkg::CH_MINUS: r_res <= r_left - r_right;
                        iee_pkg::CH_MUL:   r_res <= w_prod;
                        iee_pkg::CH_DIV: begin
                            r_res <= 32'd0;
                            if (r_right == 32'd0) r_err <= 1'b1;
                        end
                        default: begin
                            r_res <= 32'd0;
                            r_err <= 1'b1;
                        end
                    endcase
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (r_op != iee_pkg::CH_DIV || r_right == 32'd0 || w_ddone) begin
                        if (!w_vfull) begin
                            r_vmem[iee_pkg::PTR_W'(r_vtop)] <=
                                (r_op == iee_pkg::CH_DIV && r_right != 32'd0) ? w_dq : r_res;
                            r_vtop <= r_vtop + 1'b1;
                        end
                        r_state <= S_PEEK;
                    end
                end
                S_OUT: begin
                    // waits here while the previous result is still stalled
                    if (!o_valid || !i_stall) begin
                        o_value <= (r_vtop != '0) ? r_vrd : 32'hFFFF_FFFF;
                        o_error <= r_err;
                        o_valid <= 1'b1;
                        r_vtop  <= '0;
                        r_otop  <= '0;
                        r_err   <= 1'b0;
                        r_final <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/infix_expression_evaluator_top.sv */
// Top level of the two-stack infix expression evaluator.
// Depends on iee_pkg, iee_front, iee_back.
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------
// input    | in        | i_valid / o_stall  | i_symbol[7:0], i_last
// result   | out       | o_valid / i_stall  | o_value[31:0], o_error
//
// A digit or '(' without last is pushed from the idle state of the back part. An
// operator or ')' passes through peek and decide, and each reduce runs the pop1,
// pop2, calc, mul and divw states; a nonzero divide waits in divw for the
// bit-serial divider. The final flush reduces all pending operators and registers
// one result. A two-entry queue in front lets characters arrive while the back
// part reduces. The result register frees the back part at once; only a second
// result waits on a stalled first one. Reset is synchronous, low, and empties both
// stacks and the queue; no clearing pass is needed.
module infix_expression_evaluator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [7:0]   i_symbol,
    input  logic         i_last,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [31:0]  o_value,
    output logic         o_error
);
    iee_pkg::t_item w_item;
    logic w_item_valid, w_item_take;

    // front: classify and queue
    iee_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_symbol, .i_last,
        .o_item_valid(w_item_valid), .o_item(w_item), .i_item_take(w_item_take)
    );

    // back: stacks and reduce sequencer
    iee_back u_back (
        .i_clk, .i_rst_n, .i_item_valid(w_item_valid), .i_item(w_item),
        .o_item_take(w_item_take), .o_valid, .i_stall, .o_value, .o_error
    );
endmodule

/* rtl/iee_checker.sv */
// Port-level checker for the infix expression evaluator, bound to the top.
// Depends on infix_expression_evaluator_top ports only.
module iee_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_value,
    input logic        o_error
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_error))
        else $error("result changed while stalled");
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid)
        else $error("input dropped while stalled");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_value, o_error}))
        else $error("unknown result");
endmodule

bind infix_expression_evaluator_top iee_checker u_chk (.*);

/* tb/sv/infix_expression_evaluator_checker.sv */
// Checker for the infix expression evaluator: watches both channels, predicts results.
// Depends on iee_pkg for the character codes and the stack depth.
module infix_expression_evaluator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [7:0]  i_symbol,
    input  logic        i_last,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_value,
    input  logic        o_error,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic        error;
    } t_result;

    logic [31:0] vals [iee_pkg::STACK_DEPTH];
    logic [7:0]  ops [iee_pkg::STACK_DEPTH];
    int          n_vals;
    int          n_ops;
    logic        err_seen;
    t_result     expected_results [$];

    function automatic int rank(input logic [7:0] c);
        if (c == iee_pkg::CH_MUL || c == iee_pkg::CH_DIV) return 2;
        if (c == iee_pkg::CH_PLUS || c == iee_pkg::CH_MINUS) return 1;
        return 0;
    endfunction

    function automatic logic [31:0] pop_val();
        if (n_vals == 0) return 32'hFFFF_FFFF;
        n_vals--;
        return vals[n_vals];
    endfunction

    function automatic void push_val(input logic [31:0] v);
        if (n_vals < iee_pkg::STACK_DEPTH) begin
            vals[n_vals] = v;
            n_vals++;
        end
    endfunction

    function automatic void push_op(input logic [7:0] c);
        if (n_ops < iee_pkg::STACK_DEPTH) begin
            ops[n_ops] = c;
            n_ops++;
        end
    endfunction

    function automatic logic [31:0] apply_op(input logic [31:0] a, input logic [31:0] b,
                                             input logic [7:0] c);
        logic [31:0] ma, mb, q;
        if (c == iee_pkg::CH_PLUS) return a + b;
        if (c == iee_pkg::CH_MINUS) return a - b;
        if (c == iee_pkg::CH_MUL) return a * b;
        if (c == iee_pkg::CH_DIV && b != 0) begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            return (a[31] != b[31]) ? -q : q;
        end
        // bad operator or divide by zero
        err_seen = 1'b1;
        return 32'd0;
    endfunction

    function automatic void reduce_top();
        logic [31:0] r, l;
        logic [7:0]  c;
        r = pop_val();
        l = pop_val();
        c = 8'hFF;
        if (n_ops != 0) begin
            n_ops--;
            c = ops[n_ops];
        end
        push_val(apply_op(l, r, c));
    endfunction

    function automatic void evaluate_char(input logic [7:0] s, input logic lst);
        t_result res;
        if (s >= iee_pkg::CH_ZERO && s <= iee_pkg::CH_NINE) begin
            push_val(32'(s - iee_pkg::CH_ZERO));
        end else if (s == iee_pkg::CH_LPAR) begin
            push_op(s);
        end else if (s == iee_pkg::CH_RPAR) begin
            while (n_ops != 0 && ops[n_ops-1] != iee_pkg::CH_LPAR) reduce_top();
            if (n_ops != 0) n_ops--;
        end else begin
            while (n_ops != 0 && ops[n_ops-1] != iee_pkg::CH_LPAR &&
                   rank(ops[n_ops-1]) >= rank(s)) reduce_top();
            push_op(s);
        end
        if (lst) begin
            while (n_ops != 0) reduce_top();
            res.value = (n_vals != 0) ? vals[n_vals-1] : 32'hFFFF_FFFF;
            res.error = err_seen;
            expected_results.push_back(res);
            n_vals = 0;
            n_ops = 0;
            err_seen = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            n_vals = 0;
            n_ops = 0;
            err_seen = 1'b0;
            expected_results.delete();
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value=%0d error=%0b",
                             $time, $signed(o_value), o_error);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.value !== o_value || want.error !== o_error) begin
                        $display("%0t: mismatch expected value=%0d error=%0b,",
                                 $time, $signed(want.value), want.error,
                                 " actual value=%0d error=%0b",
                                 $signed(o_value), o_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (i_valid && !o_stall) evaluate_char(i_symbol, i_last);
        end
        pending_count <= expected_results.size();
    end
endmodule

/* tb/sv/infix_expression_evaluator_top_tb.sv */
// Testbench top for the infix expression evaluator: stimulus, result stalls, verdict.
// Depends on iee_pkg, infix_expression_evaluator_top and infix_expression_evaluator_checker.
module infix_expression_evaluator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_symbol = 8'h00;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_value;
    logic        o_error;
    int          fail_count;
    int          pending_count;
    int          result_count;
    bit          calm_tail = 1'b0;   // last stretch runs without idling
    int          chars_sent = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    infix_expression_evaluator_top u_top (.*);

    infix_expression_evaluator_checker u_chk (.*);

    // Receiver: stall bursts of random length, with quiet stretches between.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (!calm_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 14);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Sends one character; waits for the transfer, with an optional gap first.
    task automatic send_char(input logic [7:0] c, input logic lst);
        if (!calm_tail && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_symbol <= c;
        i_last   <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], k == s.len() - 1);
    endtask

    function automatic logic [7:0] random_digit();
        return iee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_oper();
        case ($urandom_range(0, 3))
            0: return iee_pkg::CH_PLUS;
            1: return iee_pkg::CH_MINUS;
            2: return iee_pkg::CH_MUL;
            default: return iee_pkg::CH_DIV;
        endcase
    endfunction

    // Well-formed expression with random content and some nesting.
    task automatic send_expression();
        int terms, opened;
        terms = $urandom_range(1, 8);
        opened = 0;
        for (int t = 0; t < terms; t++) begin
            if ($urandom_range(0, 3) == 0 && opened < 6) begin
                send_char(iee_pkg::CH_LPAR, 1'b0);
                opened++;
            end
            send_char(random_digit(), 1'b0);
            if (opened > 0 && $urandom_range(0, 2) == 0) begin
                send_char(iee_pkg::CH_RPAR, 1'b0);
                opened--;
            end
            if (t != terms - 1) send_char(random_oper(), 1'b0);
        end
        while (opened > 0) begin
            send_char(iee_pkg::CH_RPAR, 1'b0);
            opened--;
        end
        send_char(random_oper(), 1'b0);
        send_char(random_digit(), 1'b1);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases: all operators, precedence, parens, divide by zero,
        // bad operator, unmatched ')', empty value stack, truncation, wrap.
        send_text("1+2*3");
        send_text("(1+2)*3");
        send_text("9-7/2");
        send_text("0-7/2");
        send_text("5/0");
        send_text("3&4");
        send_text("4)");
        send_text("+");
        send_text("(");
        send_text("9*9*9*9*9*9*9*9*9*9*9");
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);

        // Hold off until every result is back.
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);

        // Full stacks: push more digits, then more '(', than either stack holds.
        for (int k = 0; k < iee_pkg::STACK_DEPTH + 4; k++)
            send_char(random_digit(), 1'b0);
        send_char(iee_pkg::CH_PLUS, 1'b1);
        for (int k = 0; k < iee_pkg::STACK_DEPTH + 4; k++)
            send_char(iee_pkg::CH_LPAR, 1'b0);
        send_char(random_digit(), 1'b1);

        // Random part: mostly well-formed expressions, some raw noise.
        while (chars_sent < 800) begin
            if (chars_sent > 700) calm_tail = 1'b1;
            if ($urandom_range(0, 4) != 0) begin
                send_expression();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_char(8'($urandom_range(0, 255)), 1'b0);
                send_char(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        i_valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("tb: %0d characters sent, %0d results checked",
                 chars_sent, result_count);
        $display("tb: covered expressions, noise and stack limits");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

/* infix_expression_evaluator_top.f */
rtl/iee_pkg.sv
rtl/iee_front.sv
rtl/iee_div.sv
rtl/iee_back.sv
rtl/infix_expression_evaluator_top.sv
rtl/iee_checker.sv
tb/sv/infix_expression_evaluator_checker.sv
tb/sv/infix_expression_evaluator_top_tb.sv
